// ===== design/assert_macros.svh =====
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// property checked on every edge, reset included
`define ASSERT_PLAIN(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

// ===== design/lzrd_pkg.sv =====
// types and constants of the lzss ring decoder
package lzrd_pkg;

   localparam int RING_AW    = 12;
   localparam int RING_DEPTH = 4096;
   localparam logic [RING_AW-1:0] RING_START = 12'd4078;
   localparam logic [4:0] MATCH_BIAS = 5'd3;
   localparam int SIZE_W = 32;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       overrun;
   } beat_type;

   typedef struct packed {
      logic               wr_en;
      logic [RING_AW-1:0] wr_addr;
      logic [7:0]         wr_data;
      logic               rd_en;
      logic [RING_AW-1:0] rd_addr;
   } ring_req_type;

endpackage

// ===== design/lzrd_ring.sv =====
// history ring memory with fill-count tracking of entries written this stream
module lzrd_ring
   import lzrd_pkg::*;
(
   input  logic               clock,
   input  ring_req_type       req,
   input  logic [RING_AW-1:0] fill_cnt,
   input  logic               fill_wrap,
   output logic [7:0]         rd_data
);

   logic [7:0]         mem [RING_DEPTH];
   logic [7:0]         rd_data_ff;
   logic               rd_live_ff;
   logic               rd_live_in;
   logic [RING_AW-1:0] rd_age;

   // distance from the stream start position, in write order
   assign rd_age     = req.rd_addr - RING_START;
   assign rd_live_in = fill_wrap || (rd_age < fill_cnt);

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
         rd_live_ff <= rd_live_in;
      end
   end

   // entries not yet written this stream read as zero
   assign rd_data = rd_live_ff ? rd_data_ff : 8'd0;

endmodule

// ===== design/lzrd_out_stage.sv =====
// output register of the result channel
module lzrd_out_stage
   import lzrd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  beat_type   beat,
   output logic       ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   output logic       rsp_overrun
);

   logic     valid_ff;
   logic     valid_in;
   beat_type beat_ff;

   assign ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         beat_ff <= beat;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = beat_ff.data;
   assign rsp_last     = beat_ff.last;
   assign rsp_overrun  = beat_ff.overrun;

endmodule

// ===== design/lzss_ring_decoder_core.sv =====
// lzss ring decoder top level: header parse, token sequencer and match copy loop
//
// Takes a compressed stream one byte per beat: an 8-byte header (little-endian
// 32-bit decoded size, then 4 ignored bytes), then flag bytes each followed by
// eight tokens, a literal byte or a two-byte match (12-bit ring offset, 4-bit
// length for 3 to 18 bytes). Header, flag and match bytes are taken without
// stall; a literal is taken once the output register is free. A match holds
// the input while it copies: each byte is a registered read of the 4096-byte
// ring followed by a state that, once the output register is free, writes it
// back at the write position and loads the output register. The ring needs no
// clearing pass: a fill count marks which entries were written since the last
// header, and the others read as zero. The last byte of a stream carries last,
// and also overrun when a match ran past the decoded size; the excess bytes
// are dropped. After the last byte, or after a header with size zero, the next
// input byte starts a new header.
module lzss_ring_decoder_core
   import lzrd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   output logic       rsp_overrun
);

   typedef enum logic [2:0] {
      ST_HEADER,
      ST_FLAG,
      ST_LIT,
      ST_MLOW,
      ST_MHIGH,
      ST_MREAD,
      ST_MEMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [2:0]         hdr_cnt_ff, hdr_cnt_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [SIZE_W-1:0]  written_ff, written_in;
   logic [7:0]         flags_ff, flags_in;
   logic [3:0]         left_ff, left_in;
   logic [7:0]         mlow_ff, mlow_in;
   logic [RING_AW-1:0] rpos_ff, rpos_in;
   logic [4:0]         mleft_ff, mleft_in;

   logic               acc;
   logic               out_ready;
   logic               beat_load;
   beat_type           beat;
   ring_req_type       ring_req;
   logic [7:0]         ring_rd_data;
   logic [RING_AW-1:0] wpos;
   logic [SIZE_W-1:0]  written_inc;
   logic               hit;
   logic [7:0]         flags_sh;
   logic [3:0]         left_dec;
   state_type          tok_next;

   function automatic state_type pick(input logic done, input logic [3:0] left,
                                      input logic f0);
      state_type nxt;
      if (done) begin
         nxt = ST_HEADER;
      end else if (left == 4'd0) begin
         nxt = ST_FLAG;
      end else if (f0) begin
         nxt = ST_LIT;
      end else begin
         nxt = ST_MLOW;
      end
      return nxt;
   endfunction

   assign req_stall = (state_ff == ST_MREAD) || (state_ff == ST_MEMIT) ||
                      ((state_ff == ST_LIT) && !out_ready);
   assign acc = req_valid && !req_stall;

   assign wpos        = RING_START + written_ff[RING_AW-1:0];
   assign written_inc = written_ff + 32'd1;
   assign hit         = (written_inc == size_ff);
   assign flags_sh    = {1'b0, flags_ff[7:1]};
   assign left_dec    = (left_ff != 4'd0) ? (left_ff - 4'd1) : 4'd0;
   assign tok_next    = pick(hit, left_dec, flags_sh[0]);

   always_comb begin
      state_in         = state_ff;
      hdr_cnt_in       = hdr_cnt_ff;
      size_in          = size_ff;
      written_in       = written_ff;
      flags_in         = flags_ff;
      left_in          = left_ff;
      mlow_in          = mlow_ff;
      rpos_in          = rpos_ff;
      mleft_in         = mleft_ff;
      ring_req         = '0;
      ring_req.wr_addr = wpos;
      ring_req.wr_data = req_in_byte;
      ring_req.rd_addr = rpos_ff;
      beat             = '0;
      beat_load        = 1'b0;
      unique case (state_ff)
         ST_FLAG: begin
            if (acc) begin
               flags_in = req_in_byte;
               left_in  = 4'd8;
               state_in = pick(written_ff == size_ff, 4'd8, req_in_byte[0]);
            end
         end
         ST_LIT: begin
            if (acc) begin
               beat.data      = req_in_byte;
               beat.last      = hit;
               beat_load      = 1'b1;
               ring_req.wr_en = 1'b1;
               written_in     = written_inc;
               flags_in       = flags_sh;
               left_in        = left_dec;
               state_in       = tok_next;
            end
         end
         ST_MLOW: begin
            if (acc) begin
               mlow_in  = req_in_byte;
               state_in = ST_MHIGH;
            end
         end
         ST_MHIGH: begin
            if (acc) begin
               rpos_in  = {req_in_byte[7:4], mlow_ff};
               mleft_in = {1'b0, req_in_byte[3:0]} + MATCH_BIAS;
               state_in = ST_MREAD;
            end
         end
         ST_MREAD: begin
            ring_req.rd_en = 1'b1;
            state_in       = ST_MEMIT;
         end
         ST_MEMIT: begin
            if (out_ready) begin
               beat.data        = ring_rd_data;
               beat.last        = hit;
               beat.overrun     = hit && (mleft_ff != 5'd1);
               beat_load        = 1'b1;
               ring_req.wr_en   = 1'b1;
               ring_req.wr_data = ring_rd_data;
               written_in       = written_inc;
               if (hit || (mleft_ff == 5'd1)) begin
                  flags_in = flags_sh;
                  left_in  = left_dec;
                  state_in = tok_next;
               end else begin
                  rpos_in  = rpos_ff + 12'd1;
                  mleft_in = mleft_ff - 5'd1;
                  state_in = ST_MREAD;
               end
            end
         end
         default: begin
            // header and unused codes
            if (acc) begin
               if (!hdr_cnt_ff[2]) begin
                  size_in[{hdr_cnt_ff[1:0], 3'b000} +: 8] = req_in_byte;
               end
               hdr_cnt_in = hdr_cnt_ff + 3'd1;
               state_in   = ST_HEADER;
               if (hdr_cnt_ff == 3'd7) begin
                  written_in = '0;
                  flags_in   = 8'd0;
                  left_in    = 4'd0;
                  hdr_cnt_in = 3'd0;
                  state_in   = pick(size_ff == '0, 4'd0, 1'b0);
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_HEADER;
         hdr_cnt_ff <= 3'd0;
         size_ff    <= '0;
         written_ff <= '0;
         flags_ff   <= 8'd0;
         left_ff    <= 4'd0;
         mlow_ff    <= 8'd0;
         rpos_ff    <= '0;
         mleft_ff   <= 5'd0;
      end else begin
         state_ff   <= state_in;
         hdr_cnt_ff <= hdr_cnt_in;
         size_ff    <= size_in;
         written_ff <= written_in;
         flags_ff   <= flags_in;
         left_ff    <= left_in;
         mlow_ff    <= mlow_in;
         rpos_ff    <= rpos_in;
         mleft_ff   <= mleft_in;
      end
   end

   lzrd_ring u_ring (
      .clock     (clock),
      .req       (ring_req),
      .fill_cnt  (written_ff[RING_AW-1:0]),
      .fill_wrap (|written_ff[SIZE_W-1:RING_AW]),
      .rd_data   (ring_rd_data)
   );

   lzrd_out_stage u_out (
      .clock        (clock),
      .reset        (reset),
      .load         (beat_load),
      .beat         (beat),
      .ready        (out_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_overrun  (rsp_overrun)
   );

endmodule

// ===== design/lzrd_checker.sv =====
// port-level checker of the lzss ring decoder and its bind
`include "assert_macros.svh"

module lzrd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_in_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last,
   input logic       rsp_overrun
);

   // a stalled result beat holds
   `ASSERT_HOLDS(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last) && $stable(rsp_overrun))

   // overrun only marks the final byte of a stream
   `ASSERT_HOLDS(a_overrun_last, clock, reset, rsp_valid |-> (!rsp_overrun || rsp_last))

   // reset empties the output register
   `ASSERT_PLAIN(a_reset_idle, clock, reset |=> !rsp_valid)

   // after reset the block waits for a header byte
   `ASSERT_PLAIN(a_reset_ready, clock, reset |=> !req_stall)

endmodule

bind lzss_ring_decoder_core lzrd_checker u_lzrd_checker (.*);
